/* sv/twt_pkg.sv */
// ============================================================================
// twt_pkg: temperature window tracker package
// Field widths, status codes, limits and the record passed between stages.
// ============================================================================
`default_nettype none

package twt_pkg;

    // Field widths
    localparam int STATUS_W = 3;
    localparam int RAW_W    = 16;
    localparam int TEMP_W   = 9;
    localparam int SUM_W    = 13;
    localparam int ERR_W    = 5;
    localparam int LIMIT_W  = 16;

    // Sample range and error saturation
    localparam logic [RAW_W-1:0]  TEMP_MAX = 16'd450;
    localparam logic [ERR_W-1:0]  ERR_SAT  = 5'd30;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'hFFFF;

    // Status codes
    localparam logic [STATUS_W-1:0] STATUS_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] STATUS_RESTART  = 3'd2;
    localparam logic [STATUS_W-1:0] STATUS_NO_DATA  = 3'd6;
    localparam logic [STATUS_W-1:0] STATUS_CHECKSUM = 3'd7;

    // Record from the window stage to the peak stage
    typedef struct packed {
        logic [SUM_W-1:0]    sum;
        logic                publish;
        logic                stored;
        logic                status_ok;
        logic                reference_valid;
        logic [STATUS_W-1:0] err_code;
        logic [ERR_W-1:0]    err_count;
    } mid_t;

endpackage

`default_nettype wire

/* sv/temperature_window_tracker_top.sv */
// ============================================================================
// temperature_window_tracker_top: windowed temperature average tracker
// Averages valid samples over a ring, tracks the peak average, raises
// attention against a configured limit and counts error statuses.
// ============================================================================
//
//  Channel  | Handshake            | Payload
//  ---------+----------------------+----------------------------------------
//  in       | in_valid / in_ready  | status, temperature, reference_valid
//  out      | out_valid / out_ready| average_temperature, peak_temperature,
//           |                      | attention, last_error, error_count
//  cfg      | cfg_write            | cfg_data (attention limit)
//
//  One beat per clock sustained while out_ready stays high; three register
//  stages (input register, ring/sum stage, reciprocal-multiply/peak stage)
//  lie between the edge that accepts an input beat and its result beat.
//  Reset clears the ring, sum, peak, counters and sets the limit to 0xFFFF.
//  Each stage loads whenever it is empty or its successor drains, so input
//  beats keep flowing into empty stages while a result waits on out_ready.
//
`default_nettype none

module temperature_window_tracker_top #(
    parameter int WINDOW = 10
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_write,
    input  wire logic [twt_pkg::LIMIT_W-1:0]   cfg_data,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [twt_pkg::STATUS_W-1:0]  status,
    input  wire logic signed [twt_pkg::RAW_W-1:0] temperature,
    input  wire logic                          reference_valid,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [twt_pkg::TEMP_W-1:0]         average_temperature,
    output logic [twt_pkg::TEMP_W-1:0]         peak_temperature,
    output logic                               attention,
    output logic [twt_pkg::STATUS_W-1:0]       last_error,
    output logic [twt_pkg::ERR_W-1:0]          error_count
);
    import twt_pkg::*;

    logic                     in_valid_reg;
    logic [STATUS_W-1:0]      status_reg;
    logic signed [RAW_W-1:0]  temperature_reg;
    logic                     reference_valid_reg;
    logic                     up_free;
    logic                     down_free;
    logic                     mid_valid;
    mid_t                     mid;
    logic                     in_take;

    // Accept into the input register when it is empty or moving on
    assign in_ready = !in_valid_reg || up_free;
    assign in_take  = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_take)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (up_free)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    // Capture the input beat
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            status_reg          <= status;
            temperature_reg     <= temperature;
            reference_valid_reg <= reference_valid;
        end
    end

    twt_window #(
        .WINDOW (WINDOW)
    ) u_window (
        .clk             (clk),
        .rst_n           (rst_n),
        .item_valid      (in_valid_reg),
        .status          (status_reg),
        .temperature     (temperature_reg),
        .reference_valid (reference_valid_reg),
        .down_free       (down_free),
        .up_free         (up_free),
        .mid_valid       (mid_valid),
        .mid             (mid)
    );

    twt_peak #(
        .WINDOW (WINDOW)
    ) u_peak (
        .clk                 (clk),
        .rst_n               (rst_n),
        .cfg_write           (cfg_write),
        .cfg_data            (cfg_data),
        .mid_valid           (mid_valid),
        .mid                 (mid),
        .down_free           (down_free),
        .out_ready           (out_ready),
        .out_valid           (out_valid),
        .average_temperature (average_temperature),
        .peak_temperature    (peak_temperature),
        .attention           (attention),
        .last_error          (last_error),
        .error_count         (error_count)
    );

    // Error count never passes saturation
    a_err_sat: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (error_count <= ERR_SAT))
        else $error("error count above saturation");

    // Peak always covers the published average
    a_peak_ge_avg: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (peak_temperature >= average_temperature))
        else $error("peak below average");

    // An empty result register never blocks the input
    a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty result register");

    // Peak never falls
    a_peak_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        $past(rst_n) |-> (peak_temperature >= $past(peak_temperature)))
        else $error("peak decreased");

endmodule

`default_nettype wire

/* sv/twt_window.sv */
// ============================================================================
// twt_window: sample ring and error bookkeeping stage
// Stores valid samples in the ring, keeps the running sum and write slot,
// counts error statuses and registers the record for the peak stage.
// ============================================================================
`default_nettype none

module twt_window #(
    parameter int WINDOW = 10
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          item_valid,
    input  wire logic [twt_pkg::STATUS_W-1:0]  status,
    input  wire logic signed [twt_pkg::RAW_W-1:0] temperature,
    input  wire logic                          reference_valid,
    input  wire logic                          down_free,
    output logic                               up_free,
    output logic                               mid_valid,
    output twt_pkg::mid_t                      mid
);
    import twt_pkg::*;

    localparam int SLOT_W = $clog2(WINDOW);
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(WINDOW - 1);

    logic [TEMP_W-1:0]   ring_reg [WINDOW];
    logic [SUM_W-1:0]    sum_reg;
    logic [SUM_W-1:0]    sum_next;
    logic [SLOT_W-1:0]   slot_reg;
    logic [SLOT_W-1:0]   slot_next;
    logic                published_reg;
    logic [STATUS_W-1:0] err_code_reg;
    logic [STATUS_W-1:0] err_code_next;
    logic [ERR_W-1:0]    err_cnt_reg;
    logic [ERR_W-1:0]    err_cnt_next;
    logic                mid_valid_reg;
    mid_t                mid_reg;
    mid_t                mid_next;

    logic                move;
    logic                in_range;
    logic                stored;
    logic                counted;
    logic                wrap;
    logic [TEMP_W-1:0]   old_sample;
    logic [TEMP_W-1:0]   new_sample;

    // Advance when the record register is empty or being drained
    assign up_free = !mid_valid_reg || down_free;
    assign move    = item_valid && up_free;

    // Classify the beat
    always_comb
    begin
        in_range   = !temperature[RAW_W-1] && (temperature != '0)
                     && (unsigned'(temperature) <= TEMP_MAX);
        stored     = move && (status == STATUS_OK) && in_range;
        counted    = status inside {STATUS_RESTART, STATUS_NO_DATA, STATUS_CHECKSUM};
        wrap       = (slot_reg == LAST_SLOT);
        old_sample = ring_reg[slot_reg];
        new_sample = temperature[TEMP_W-1:0];
    end

    // Running sum, slot and error counter updates
    always_comb
    begin
        sum_next      = sum_reg;
        slot_next     = slot_reg;
        err_code_next = err_code_reg;
        err_cnt_next  = err_cnt_reg;
        if (stored)
        begin
            sum_next  = sum_reg - SUM_W'(old_sample) + SUM_W'(new_sample);
            slot_next = wrap ? '0 : slot_reg + 1'b1;
        end
        if (move && counted)
        begin
            err_code_next = status;
            if (err_cnt_reg < ERR_SAT)
            begin
                err_cnt_next = err_cnt_reg + 1'b1;
            end
        end
    end

    // Build the record for the peak stage
    always_comb
    begin
        mid_next.sum             = sum_next;
        mid_next.publish         = wrap || published_reg;
        mid_next.stored          = stored;
        mid_next.status_ok       = (status == STATUS_OK);
        mid_next.reference_valid = reference_valid;
        mid_next.err_code        = err_code_next;
        mid_next.err_count       = err_cnt_next;
    end

    // Hold ring and bookkeeping state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < WINDOW; i++)
            begin
                ring_reg[i] <= '0;
            end
            sum_reg       <= '0;
            slot_reg      <= '0;
            published_reg <= 1'b0;
            err_code_reg  <= '0;
            err_cnt_reg   <= '0;
            mid_valid_reg <= 1'b0;
        end
        else
        begin
            if (stored)
            begin
                ring_reg[slot_reg] <= new_sample;
                if (wrap)
                begin
                    published_reg <= 1'b1;
                end
            end
            sum_reg      <= sum_next;
            slot_reg     <= slot_next;
            err_code_reg <= err_code_next;
            err_cnt_reg  <= err_cnt_next;
            if (move)
            begin
                mid_valid_reg <= 1'b1;
            end
            else if (down_free)
            begin
                mid_valid_reg <= 1'b0;
            end
        end
    end

    // Record payload needs no reset
    always_ff @(posedge clk)
    begin
        if (move)
        begin
            mid_reg <= mid_next;
        end
    end

    assign mid_valid = mid_valid_reg;
    assign mid       = mid_reg;

endmodule

`default_nettype wire

/* sv/twt_peak.sv */
// ============================================================================
// twt_peak: average, peak and attention stage
// Divides the window sum by the window length through a reciprocal multiply,
// tracks the peak average, evaluates attention and holds the result beat.
// ============================================================================
`default_nettype none

module twt_peak #(
    parameter int WINDOW = 10
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_write,
    input  wire logic [twt_pkg::LIMIT_W-1:0]   cfg_data,
    input  wire logic                          mid_valid,
    input  wire twt_pkg::mid_t                 mid,
    output logic                               down_free,
    input  wire logic                          out_ready,
    output logic                               out_valid,
    output logic [twt_pkg::TEMP_W-1:0]         average_temperature,
    output logic [twt_pkg::TEMP_W-1:0]         peak_temperature,
    output logic                               attention,
    output logic [twt_pkg::STATUS_W-1:0]       last_error,
    output logic [twt_pkg::ERR_W-1:0]          error_count
);
    import twt_pkg::*;

    // floor(x / WINDOW) == (x * RECIP) >> SHIFT for every SUM_W-bit x
    localparam int SHIFT  = SUM_W + $clog2(WINDOW);
    localparam longint unsigned RECIP_FULL =
        ((64'd1 << SHIFT) + WINDOW - 1) / WINDOW;
    localparam int RECIP_W = SUM_W + 1;
    localparam int PROD_W  = SUM_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_FULL[RECIP_W-1:0];

    logic [LIMIT_W-1:0]  limit_reg;
    logic                out_valid_reg;
    logic [TEMP_W-1:0]   average_reg;
    logic [TEMP_W-1:0]   average_next;
    logic [TEMP_W-1:0]   peak_reg;
    logic [TEMP_W-1:0]   peak_next;
    logic                attention_reg;
    logic                attention_next;
    logic [STATUS_W-1:0] last_error_reg;
    logic [ERR_W-1:0]    error_count_reg;

    logic                move;
    logic [PROD_W-1:0]   product;
    logic [TEMP_W-1:0]   quotient;

    assign down_free = !out_valid_reg || out_ready;
    assign move      = mid_valid && down_free;

    // Divide the sum by the window length
    assign product  = PROD_W'(mid.sum) * PROD_W'(RECIP);
    assign quotient = product[SHIFT +: TEMP_W];

    // Update average, peak and attention
    always_comb
    begin
        average_next   = average_reg;
        peak_next      = peak_reg;
        attention_next = attention_reg;
        if (mid.stored && mid.publish)
        begin
            average_next = quotient;
            if (quotient > peak_reg)
            begin
                peak_next = quotient;
            end
        end
        if (mid.status_ok)
        begin
            attention_next = mid.reference_valid
                             && (LIMIT_W'(peak_next) >= limit_reg);
        end
    end

    // Hold the limit, the tracking state and the result beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg       <= LIMIT_RESET;
            out_valid_reg   <= 1'b0;
            average_reg     <= '0;
            peak_reg        <= '0;
            attention_reg   <= 1'b0;
            last_error_reg  <= '0;
            error_count_reg <= '0;
        end
        else
        begin
            if (cfg_write)
            begin
                limit_reg <= cfg_data;
            end
            if (move)
            begin
                out_valid_reg   <= 1'b1;
                average_reg     <= average_next;
                peak_reg        <= peak_next;
                attention_reg   <= attention_next;
                last_error_reg  <= mid.err_code;
                error_count_reg <= mid.err_count;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid           = out_valid_reg;
    assign average_temperature = average_reg;
    assign peak_temperature    = peak_reg;
    assign attention           = attention_reg;
    assign last_error          = last_error_reg;
    assign error_count         = error_count_reg;

endmodule

`default_nettype wire
